/* hw/rtl/gws_pkg.sv */
// shared types, constants and commands for the eight-way grid word search
`timescale 1ns / 1ps
`default_nettype none
package gws_pkg;

    localparam int GRID_MAX  = 64;
    localparam int WORDS_MAX = 32;
    localparam int LEN_MAX   = 16;
    localparam int DIRS      = 8;

    localparam int COORD_W = $clog2(GRID_MAX);
    localparam int WIDX_W  = $clog2(WORDS_MAX);
    localparam int LIDX_W  = $clog2(LEN_MAX);
    localparam int LEN_W   = $clog2(LEN_MAX + 1);
    localparam int DIR_W   = $clog2(DIRS);
    localparam int CFG_W   = 7;
    localparam int SIDE_W  = 7;
    localparam int CNT_W   = 6;

    typedef enum logic [1:0] {
        OP_GRID  = 2'd0,
        OP_WORD  = 2'd1,
        OP_RUN   = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic {
        REG_GRID_SIDE  = 1'b0,
        REG_WORD_COUNT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [5:0] row;
        logic [5:0] col;
        logic [7:0] char_value;
        logic [4:0] word_index;
        logic [3:0] letter_index;
        logic       last_letter;
    } in_item_t;

    typedef struct packed {
        logic [4:0] result_word;
        logic       found;
        logic [5:0] start_col;
        logic [5:0] start_row;
        logic       last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WORD,
        ST_LEN,
        ST_CELL,
        ST_FIRST,
        ST_DIR,
        ST_READ,
        ST_CMP,
        ST_NEXT,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_len;     // capture registered length read
        logic word_start;   // reset cell scan for current word
        logic read_first;   // issue reads of first letter at start cell, first direction
        logic dir_start;    // begin direction at j = 1
        logic read_step;    // issue reads at step j
        logic step_adv;     // j++
        logic dir_adv;      // next direction
        logic cell_adv;     // next start cell
        logic word_adv;     // next word
        logic hit;          // record match at current cell
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic len_zero;
        logic len_one;
        logic first_eq;
        logic step_eq;
        logic step_last;    // j == len-1
        logic dir_in;       // end point inside grid
        logic dir_last;
        logic cell_last;
        logic word_last;
        logic no_words;
        logic no_cells;
    } stat_t;

    function automatic logic signed [3:0] step_dx(input logic [DIR_W-1:0] d);
        logic signed [3:0] v;
        begin
            unique case (d)
                3'd0: v = 4'sd0;
                3'd1: v = -4'sd1;
                3'd2: v = -4'sd1;
                3'd3: v = -4'sd1;
                3'd4: v = 4'sd0;
                3'd5: v = 4'sd1;
                3'd6: v = 4'sd1;
                default: v = 4'sd1;
            endcase
            step_dx = v;
        end
    endfunction

    function automatic logic signed [3:0] step_dy(input logic [DIR_W-1:0] d);
        logic signed [3:0] v;
        begin
            unique case (d)
                3'd0: v = 4'sd1;
                3'd1: v = 4'sd1;
                3'd2: v = 4'sd0;
                3'd3: v = -4'sd1;
                3'd4: v = -4'sd1;
                3'd5: v = -4'sd1;
                3'd6: v = 4'sd0;
                default: v = 4'sd1;
            endcase
            step_dy = v;
        end
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/gws_datapath.sv */
// grid, word and length memories, scan counters and compare logic
`timescale 1ns / 1ps
`default_nettype none
module gws_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gws_pkg::in_item_t in_item,
    input  wire logic              wr_grid,
    input  wire logic              wr_word,
    input  wire logic [6:0]        grid_side_reg,
    input  wire logic [5:0]        word_count_reg,
    input  wire gws_pkg::cmd_t     cmd,
    output gws_pkg::stat_t         stat,
    output gws_pkg::out_item_t     result
);
    import gws_pkg::*;

    localparam int GADDR_W = 2 * COORD_W;
    localparam int WADDR_W = WIDX_W + LIDX_W;
    localparam int SC_W    = COORD_W + 3;  // signed coordinate with room for steps

    logic [7:0]       grid_mem [GRID_MAX*GRID_MAX];
    logic [7:0]       word_mem [WORDS_MAX*LEN_MAX];
    logic [LEN_W-1:0] len_mem  [WORDS_MAX];

    logic [7:0]          grid_q_reg, word_q_reg;
    logic [LEN_W-1:0]    len_q_reg, len_reg;
    logic [WIDX_W-1:0]   w_reg;
    logic [COORD_W-1:0]  x_reg, y_reg;
    logic [DIR_W-1:0]    d_reg;
    logic [LIDX_W-1:0]   j_reg;
    logic signed [SC_W-1:0] cx_reg, cy_reg;
    logic                found_reg;
    logic [COORD_W-1:0]  bx_reg, by_reg;

    logic [SIDE_W-1:0] n;
    logic [CNT_W-1:0]  cnt;
    assign n   = (grid_side_reg > SIDE_W'(GRID_MAX)) ? SIDE_W'(GRID_MAX) : grid_side_reg;
    assign cnt = (word_count_reg > CNT_W'(WORDS_MAX)) ? CNT_W'(WORDS_MAX) : word_count_reg;

    // step offsets and end point of current direction
    logic signed [3:0]      dx, dy;
    logic signed [SC_W-1:0] ex, ey, lm1, n_s;
    assign dx  = step_dx(d_reg);
    assign dy  = step_dy(d_reg);
    assign lm1 = SC_W'(len_reg) - SC_W'(1);
    assign ex  = $signed({3'b000, x_reg}) + SC_W'(dx) * lm1;
    assign ey  = $signed({3'b000, y_reg}) + SC_W'(dy) * lm1;
    assign n_s = $signed({2'b00, n});

    logic [GADDR_W-1:0] raddr_g;
    logic [WADDR_W-1:0] raddr_w;
    always_comb
    begin
        raddr_g = {y_reg, x_reg};
        raddr_w = {w_reg, {LIDX_W{1'b0}}};
        if (cmd.read_step)
        begin
            raddr_g = {cy_reg[COORD_W-1:0], cx_reg[COORD_W-1:0]};
            raddr_w = {w_reg, j_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_grid)
            grid_mem[{in_item.row, in_item.col}] <= in_item.char_value;
        if (wr_word)
            word_mem[{in_item.word_index, in_item.letter_index}] <= in_item.char_value;
        if (wr_word && in_item.last_letter)
            len_mem[in_item.word_index] <= LEN_W'(in_item.letter_index) + LEN_W'(1);
        grid_q_reg <= grid_mem[raddr_g];
        word_q_reg <= word_mem[raddr_w];
        len_q_reg  <= len_mem[w_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            w_reg     <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            d_reg     <= '0;
            j_reg     <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            found_reg <= 1'b0;
            bx_reg    <= '0;
            by_reg    <= '0;
        end
        else
        begin
            if (cmd.load_len)
                len_reg <= len_q_reg;
            if (cmd.word_start)
            begin
                x_reg     <= '0;
                y_reg     <= '0;
                found_reg <= 1'b0;
                bx_reg    <= '0;
                by_reg    <= '0;
            end
            if (cmd.read_first)
                d_reg <= '0;
            if (cmd.dir_start)
            begin
                j_reg  <= LIDX_W'(1);
                cx_reg <= $signed({3'b000, x_reg}) + SC_W'(dx);
                cy_reg <= $signed({3'b000, y_reg}) + SC_W'(dy);
            end
            if (cmd.step_adv)
            begin
                j_reg  <= j_reg + LIDX_W'(1);
                cx_reg <= cx_reg + SC_W'(dx);
                cy_reg <= cy_reg + SC_W'(dy);
            end
            if (cmd.dir_adv)
                d_reg <= d_reg + DIR_W'(1);
            if (cmd.cell_adv)
            begin
                // column-major scan: row runs fastest
                if ({1'b0, y_reg} == n - SIDE_W'(1))
                begin
                    y_reg <= '0;
                    x_reg <= x_reg + COORD_W'(1);
                end
                else
                    y_reg <= y_reg + COORD_W'(1);
            end
            if (cmd.hit)
            begin
                found_reg <= 1'b1;
                bx_reg    <= x_reg;
                by_reg    <= y_reg;
            end
            if (cmd.word_adv)
            begin
                if (stat.word_last)
                    w_reg <= '0;
                else
                    w_reg <= w_reg + WIDX_W'(1);
            end
        end
    end

    always_comb
    begin
        stat.len_zero  = (len_reg == '0);
        stat.len_one   = (len_reg == LEN_W'(1));
        stat.first_eq  = (grid_q_reg == word_q_reg);
        stat.step_eq   = (grid_q_reg == word_q_reg);
        stat.step_last = (LEN_W'(j_reg) == len_reg - LEN_W'(1));
        stat.dir_in    = (ex >= 0) && (ex < n_s) && (ey >= 0) && (ey < n_s);
        stat.dir_last  = (d_reg == DIR_W'(DIRS - 1));
        stat.cell_last = ({1'b0, y_reg} == n - SIDE_W'(1)) && ({1'b0, x_reg} == n - SIDE_W'(1));
        stat.word_last = ({1'b0, w_reg} == cnt - CNT_W'(1));
        stat.no_words  = (cnt == '0);
        stat.no_cells  = (n == '0);

        result.result_word = w_reg;
        result.found       = found_reg;
        result.start_col   = bx_reg;
        result.start_row   = by_reg;
        result.last        = stat.word_last;
    end

endmodule
`default_nettype wire

/* hw/rtl/gws_ctrl.sv */
// search sequencer: walks words, start cells, directions and letters
`timescale 1ns / 1ps
`default_nettype none
module gws_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           run,
    input  wire gws_pkg::stat_t stat,
    input  wire logic           out_free,
    output logic                busy,
    output logic                emit,
    output gws_pkg::cmd_t       cmd
);
    import gws_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        emit       = 1'b0;
        busy       = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (run && !stat.no_words)
                    state_next = ST_WORD;
            end
            ST_WORD:
            begin
                // length memory read in flight
                cmd.word_start = 1'b1;
                state_next     = ST_LEN;
            end
            ST_LEN:
            begin
                cmd.load_len = 1'b1;
                state_next   = ST_CELL;
            end
            ST_CELL:
            begin
                if (stat.len_zero || stat.no_cells)
                    state_next = ST_EMIT;
                else
                begin
                    cmd.read_first = 1'b1;
                    state_next     = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                if (!stat.first_eq)
                    state_next = ST_NEXT;
                else if (stat.len_one)
                begin
                    cmd.hit    = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                    state_next = ST_DIR;
            end
            ST_DIR:
            begin
                if (stat.dir_in)
                begin
                    cmd.dir_start = 1'b1;
                    state_next    = ST_READ;
                end
                else if (stat.dir_last)
                    state_next = ST_NEXT;
                else
                    cmd.dir_adv = 1'b1;
            end
            ST_READ:
            begin
                cmd.read_step = 1'b1;
                state_next    = ST_CMP;
            end
            ST_CMP:
            begin
                if (stat.step_eq && stat.step_last)
                begin
                    cmd.hit    = 1'b1;
                    state_next = ST_EMIT;
                end
                else if (stat.step_eq)
                begin
                    cmd.step_adv = 1'b1;
                    state_next   = ST_READ;
                end
                else if (stat.dir_last)
                    state_next = ST_NEXT;
                else
                begin
                    cmd.dir_adv = 1'b1;
                    state_next  = ST_DIR;
                end
            end
            ST_NEXT:
            begin
                if (stat.cell_last)
                    state_next = ST_EMIT;
                else
                begin
                    cmd.cell_adv = 1'b1;
                    state_next   = ST_CELL;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    emit         = 1'b1;
                    cmd.word_adv = 1'b1;
                    state_next   = stat.word_last ? ST_IDLE : ST_WORD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

/* hw/rtl/grid_word_search_eight_way.sv */
// top level of the eight-way grid word search
`timescale 1ns / 1ps
`default_nettype none
// Eight-way word search. Grid-cell and word-letter writes are accepted back to back. A run
// walks words in order; for each word it scans start cells column by column, and at a cell
// whose letter matches the first letter it tries the eight directions, reading and then
// comparing one letter at a time through the single grid memory read port and stopping at
// the first hit; results leave through a one-entry output register, and a word waits while
// that register is full and stalled. Input is stalled while a run is in progress.
module grid_word_search_eight_way (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire gws_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output gws_pkg::out_item_t      out_data,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [6:0]         cfg_data
);
    import gws_pkg::*;

    logic [SIDE_W-1:0] grid_side_reg;
    logic [CNT_W-1:0]  word_count_reg;
    cmd_t      cmd;
    stat_t     stat;
    out_item_t result;
    logic      busy, emit, in_xfer, run, wr_grid, wr_word, out_free;
    logic      out_valid_reg;
    out_item_t out_data_reg;

    assign in_stall = busy;
    assign in_xfer  = in_valid && !in_stall;
    assign run      = in_xfer && (in_data.operation == OP_RUN);
    assign wr_grid  = in_xfer && (in_data.operation == OP_GRID);
    assign wr_word  = in_xfer && (in_data.operation == OP_WORD);
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_side_reg  <= SIDE_W'(GRID_MAX);
            word_count_reg <= CNT_W'(1);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_GRID_SIDE)
                grid_side_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_WORD_COUNT)
                word_count_reg <= cfg_data[CNT_W-1:0];
            if (emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    gws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .run      (run),
        .stat     (stat),
        .out_free (out_free),
        .busy     (busy),
        .emit     (emit),
        .cmd      (cmd)
    );

    gws_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_item        (in_data),
        .wr_grid        (wr_grid),
        .wr_word        (wr_word),
        .grid_side_reg  (grid_side_reg),
        .word_count_reg (word_count_reg),
        .cmd            (cmd),
        .stat           (stat),
        .result         (result)
    );

endmodule
`default_nettype wire

/* hw/rtl/gws_checker.sv */
// port-level checks for the word search, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module gws_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire gws_pkg::in_item_t  in_data,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire gws_pkg::out_item_t out_data
);
    import gws_pkg::*;

    // a presented result carries known bits
    a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown(out_data))
        else $error("unknown result bits");

    // load items never stall the input
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall && in_valid && in_data.operation != OP_RUN |=> !in_stall)
        else $error("load stalled input");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output dropped while stalled");

    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.found |-> out_data.start_col == '0 && out_data.start_row == '0)
        else $error("position set on a miss");

endmodule

bind grid_word_search_eight_way gws_checker u_gws_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
`default_nettype wire
